@@ hdl/iqbd_pkg.sv @@
// Shared types and constants for the I/Q boxcar decimator.
`timescale 1ns / 1ps

package iqbd_pkg;

   // Frame and window limits
   localparam int FRAME_W           = 21;
   localparam int COUNT_W           = 11;
   localparam int SAMPLE_W          = 16;
   localparam int SUM_W             = 27;
   localparam int OUT_SHIFT         = 10;
   localparam logic [FRAME_W-1:0] MAX_OUTPUTS       = 21'd1024;
   localparam logic [FRAME_W-1:0] MAX_FRAME_SAMPLES = 21'd1048576;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Divider steps: the mean always fits in 16 bits
   localparam int DIV_STEPS  = 16;
   localparam int STEP_W     = 4;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_i;
      logic signed [SAMPLE_W-1:0] sample_q;
   } iqbd_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] avg_i;
      logic signed [SAMPLE_W-1:0] avg_q;
      logic                       frame_last;
   } iqbd_rsp_type;

   // One finished window, waiting for the divide
   typedef struct packed {
      logic signed [SUM_W-1:0] sum_i;
      logic signed [SUM_W-1:0] sum_q;
      logic [COUNT_W-1:0]      divisor;
      logic                    last;
   } iqbd_job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } iqbd_qstat_type;

endpackage

@@ hdl/iqbd_front.sv @@
// Front end: takes samples, accumulates windows, tracks frame position.
`timescale 1ns / 1ps

module iqbd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [iqbd_pkg::FRAME_W-1:0]   csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  iqbd_pkg::iqbd_req_type         req_data,
   input  iqbd_pkg::iqbd_qstat_type       qstat,
   output logic                           job_valid,
   output iqbd_pkg::iqbd_job_type         job
);
   import iqbd_pkg::*;

   logic [FRAME_W-1:0]      len_ff, len_in;
   logic [COUNT_W-1:0]      ocount_ff, ocount_in;
   logic [COUNT_W-1:0]      wlen_ff, wlen_in;
   logic signed [SUM_W-1:0] sum_i_ff, sum_i_in;
   logic signed [SUM_W-1:0] sum_q_ff, sum_q_in;
   logic [COUNT_W-1:0]      fill_ff, fill_in;
   logic [COUNT_W-1:0]      done_ff, done_in;
   logic [FRAME_W-1:0]      pos_ff, pos_in;

   logic [FRAME_W-1:0]      eff_len;
   logic                    accept;
   logic                    active;
   logic                    win_end;
   logic                    frame_end;
   logic signed [SUM_W-1:0] sum_i_add, sum_q_add;
   logic [COUNT_W-1:0]      fill_inc, done_inc;
   logic [FRAME_W-1:0]      pos_inc;

   // Clamp written length into 1 .. max frame
   always_comb begin
      eff_len = csr_wdata;
      if (csr_wdata == '0) begin
         eff_len = FRAME_W'(1);
      end else if (csr_wdata > MAX_FRAME_SAMPLES) begin
         eff_len = MAX_FRAME_SAMPLES;
      end
   end

   // Hold off while the queue cannot take a window
   assign req_stall = qstat.full;
   assign accept    = req_valid & ~req_stall;

   assign active    = done_ff < ocount_ff;
   assign sum_i_add = sum_i_ff + SUM_W'(req_data.sample_i);
   assign sum_q_add = sum_q_ff + SUM_W'(req_data.sample_q);
   assign fill_inc  = fill_ff + COUNT_W'(1);
   assign done_inc  = done_ff + COUNT_W'(1);
   assign pos_inc   = pos_ff + FRAME_W'(1);
   assign win_end   = active && (fill_inc >= wlen_ff);
   assign frame_end = pos_inc >= len_ff;

   // Window completion goes to the queue
   assign job_valid   = accept && win_end;
   assign job.sum_i   = sum_i_add;
   assign job.sum_q   = sum_q_add;
   assign job.divisor = wlen_ff;
   assign job.last    = (done_inc == ocount_ff);

   // Next state
   always_comb begin
      len_in    = len_ff;
      ocount_in = ocount_ff;
      wlen_in   = wlen_ff;
      sum_i_in  = sum_i_ff;
      sum_q_in  = sum_q_ff;
      fill_in   = fill_ff;
      done_in   = done_ff;
      pos_in    = pos_ff;
      if (csr_we) begin
         len_in    = eff_len;
         ocount_in = (eff_len < MAX_OUTPUTS) ? eff_len[COUNT_W-1:0]
                                             : MAX_OUTPUTS[COUNT_W-1:0];
         wlen_in   = (eff_len <= MAX_OUTPUTS) ? COUNT_W'(1)
                                              : eff_len[FRAME_W-1:OUT_SHIFT];
         sum_i_in  = '0;
         sum_q_in  = '0;
         fill_in   = '0;
         done_in   = '0;
         pos_in    = '0;
      end else if (accept) begin
         if (active) begin
            sum_i_in = sum_i_add;
            sum_q_in = sum_q_add;
            fill_in  = fill_inc;
            if (win_end) begin
               sum_i_in = '0;
               sum_q_in = '0;
               fill_in  = '0;
               done_in  = done_inc;
            end
         end
         if (frame_end) begin
            sum_i_in = '0;
            sum_q_in = '0;
            fill_in  = '0;
            done_in  = '0;
            pos_in   = '0;
         end else begin
            pos_in = pos_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= MAX_OUTPUTS;
         ocount_ff <= MAX_OUTPUTS[COUNT_W-1:0];
         wlen_ff   <= COUNT_W'(1);
         sum_i_ff  <= '0;
         sum_q_ff  <= '0;
         fill_ff   <= '0;
         done_ff   <= '0;
         pos_ff    <= '0;
      end else begin
         len_ff    <= len_in;
         ocount_ff <= ocount_in;
         wlen_ff   <= wlen_in;
         sum_i_ff  <= sum_i_in;
         sum_q_ff  <= sum_q_in;
         fill_ff   <= fill_in;
         done_ff   <= done_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

@@ hdl/iqbd_fifo.sv @@
// Two-entry job queue between the front end and the divider.
`timescale 1ns / 1ps

module iqbd_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  iqbd_pkg::iqbd_job_type    push_job,
   input  logic                      pop,
   output iqbd_pkg::iqbd_job_type    head_job,
   output iqbd_pkg::iqbd_qstat_type  qstat
);
   import iqbd_pkg::*;

   iqbd_job_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_job    = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ hdl/iqbd_divider.sv @@
// Back end: floor mean of I and Q by a bit-serial divide, then output register.
`timescale 1ns / 1ps

module iqbd_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  iqbd_pkg::iqbd_qstat_type  qstat,
   input  iqbd_pkg::iqbd_job_type    head_job,
   output logic                      job_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output iqbd_pkg::iqbd_rsp_type    rsp_data
);
   import iqbd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [COUNT_W-1:0]  div_ff, div_in;
   logic [COUNT_W-1:0]  rem_i_ff, rem_i_in, rem_q_ff, rem_q_in;
   logic [SAMPLE_W-1:0] work_i_ff, work_i_in, work_q_ff, work_q_in;
   logic                neg_i_ff, neg_i_in, neg_q_ff, neg_q_in;
   logic                last_ff, last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   iqbd_rsp_type        rsp_data_ff, rsp_data_in;

   logic [SUM_W-1:0]    mag_i, mag_q;
   logic [COUNT_W:0]    cand_i, cand_q;
   logic                ge_i, ge_q;
   logic [COUNT_W:0]    diff_i, diff_q;
   logic                out_free;

   // floor(s/d) = s >= 0 ? s/d : ~(~s/d), so the divide stays unsigned
   assign mag_i = head_job.sum_i[SUM_W-1] ? ~head_job.sum_i : head_job.sum_i;
   assign mag_q = head_job.sum_q[SUM_W-1] ? ~head_job.sum_q : head_job.sum_q;

   // One restoring step per cycle on each lane
   assign cand_i = {rem_i_ff, work_i_ff[SAMPLE_W-1]};
   assign cand_q = {rem_q_ff, work_q_ff[SAMPLE_W-1]};
   assign ge_i   = cand_i >= {1'b0, div_ff};
   assign ge_q   = cand_q >= {1'b0, div_ff};
   assign diff_i = cand_i - {1'b0, div_ff};
   assign diff_q = cand_q - {1'b0, div_ff};

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign job_pop  = (state_ff == ST_IDLE) && !qstat.empty;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      div_in       = div_ff;
      rem_i_in     = rem_i_ff;
      rem_q_in     = rem_q_ff;
      work_i_in    = work_i_ff;
      work_q_in    = work_q_ff;
      neg_i_in     = neg_i_ff;
      neg_q_in     = neg_q_ff;
      last_in      = last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_pop) begin
               div_in    = head_job.divisor;
               rem_i_in  = {1'b0, mag_i[SUM_W-2:SAMPLE_W]};
               rem_q_in  = {1'b0, mag_q[SUM_W-2:SAMPLE_W]};
               work_i_in = mag_i[SAMPLE_W-1:0];
               work_q_in = mag_q[SAMPLE_W-1:0];
               neg_i_in  = head_job.sum_i[SUM_W-1];
               neg_q_in  = head_job.sum_q[SUM_W-1];
               last_in   = head_job.last;
               step_in   = '0;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            rem_i_in  = ge_i ? diff_i[COUNT_W-1:0] : cand_i[COUNT_W-1:0];
            rem_q_in  = ge_q ? diff_q[COUNT_W-1:0] : cand_q[COUNT_W-1:0];
            work_i_in = {work_i_ff[SAMPLE_W-2:0], ge_i};
            work_q_in = {work_q_ff[SAMPLE_W-2:0], ge_q};
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_data_in.avg_i      = neg_i_ff ? ~work_i_ff : work_i_ff;
               rsp_data_in.avg_q      = neg_q_ff ? ~work_q_ff : work_q_ff;
               rsp_data_in.frame_last = last_ff;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      div_ff      <= div_in;
      rem_i_ff    <= rem_i_in;
      rem_q_ff    <= rem_q_in;
      work_i_ff   <= work_i_in;
      work_q_ff   <= work_q_in;
      neg_i_ff    <= neg_i_in;
      neg_q_ff    <= neg_q_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/iq_boxcar_decimator_core.sv @@
// Top level of the I/Q boxcar averaging decimator.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   request | req_valid, req_stall, req_data     | in
//   result  | rsp_valid, rsp_stall, rsp_data     | out
//   control | csr_we, csr_wdata (frame length)   | in
//
// Each window is queued for the divider, which loads it, divides I and Q in
// parallel, then hands the result to the output register. With rsp_stall low,
// windows at least as long as a divide take one sample per cycle; shorter ones
// are bound by the divider. Reset (synchronous) sets the frame length to 1024.
// req_stall rises when the two-entry queue is full; rsp_stall holds the output
// register and divider while the front end runs on until the queue fills.
`timescale 1ns / 1ps

module iq_boxcar_decimator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [iqbd_pkg::FRAME_W-1:0]  csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  iqbd_pkg::iqbd_req_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output iqbd_pkg::iqbd_rsp_type        rsp_data
);
   import iqbd_pkg::*;

   iqbd_qstat_type qstat;
   iqbd_job_type   push_job;
   iqbd_job_type   head_job;
   logic           job_valid;
   logic           job_pop;

   iqbd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .qstat     (qstat),
      .job_valid (job_valid),
      .job       (push_job)
   );

   iqbd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_valid),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   iqbd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .head_job  (head_job),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // A finished window never lands on a full queue
   assert property (@(posedge clock) disable iff (reset) job_valid |-> !qstat.full)
      else $error("window pushed into full queue");

   // The divider only takes a job that is there
   assert property (@(posedge clock) disable iff (reset) job_pop |-> !qstat.empty)
      else $error("job popped from empty queue");

   // Queue cannot be full and empty together
   assert property (@(posedge clock) disable iff (reset) !(qstat.full && qstat.empty))
      else $error("queue status inconsistent");
`endif

endmodule

@@ tb/tb_iq_boxcar_decimator_core.sv @@
// Self-checking testbench for the I/Q boxcar averaging decimator core.
`timescale 1ns / 1ps

module tb_iq_boxcar_decimator_core;
   import iqbd_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES = 48;   // divider plus queue, with margin
   localparam int MAX_WAIT     = 11;

   typedef enum {FILL_RANDOM, FILL_HIGH, FILL_LOW} fill_kind_type;

   // Window sums and frame position, plus the averages the block still owes
   class boxcar_tracker;
      int unsigned span, win_len, win_count, fill, emitted, taken;
      longint acc_i, acc_q;
      iqbd_rsp_type pending_means[$];
      int unsigned mismatches, checked;

      function new();
         mismatches = 0;
         checked = 0;
         set_length(21'd1024);
      endfunction

      function void restart();
         acc_i = 0;
         acc_q = 0;
         fill = 0;
         emitted = 0;
         taken = 0;
      endfunction

      // Zero acts as one, anything past the frame limit is clamped
      function void set_length(logic [FRAME_W-1:0] len);
         span = (len == 0) ? 1 : len;
         if (span > MAX_FRAME_SAMPLES) span = MAX_FRAME_SAMPLES;
         win_count = (span < MAX_OUTPUTS) ? span : MAX_OUTPUTS;
         win_len = span / win_count;
         restart();
      endfunction

      // Mean rounded toward minus infinity, kept to 16 bits
      function logic signed [SAMPLE_W-1:0] floor_mean(longint total);
         longint q;
         q = total / longint'(win_len);
         if ((total % longint'(win_len)) != 0 && total < 0) q -= 1;
         return q[SAMPLE_W-1:0];
      endfunction

      function void take_sample(iqbd_req_type s);
         iqbd_rsp_type mean;
         if (emitted < win_count) begin
            acc_i += longint'(s.sample_i);
            acc_q += longint'(s.sample_q);
            fill++;
            if (fill >= win_len) begin
               mean.avg_i = floor_mean(acc_i);
               mean.avg_q = floor_mean(acc_q);
               emitted++;
               mean.frame_last = (emitted == win_count);
               pending_means.push_back(mean);
               acc_i = 0;
               acc_q = 0;
               fill = 0;
            end
         end
         // frame ends after span samples, leftovers past the last window included
         if (taken + 1 >= span) restart();
         else taken++;
      endfunction

      function int owed();
         return pending_means.size();
      endfunction

      task note_mismatch(string what);
         mismatches++;
         $display("%0t mismatch: %s", $time, what);
      endtask

      task match_average(iqbd_rsp_type got);
         iqbd_rsp_type want;
         checked++;
         if (pending_means.size() == 0) begin
            note_mismatch($sformatf("average %0d/%0d arrived with none owed",
                                    got.avg_i, got.avg_q));
            return;
         end
         want = pending_means.pop_front();
         if (got.avg_i !== want.avg_i)
            note_mismatch($sformatf("avg_i %0d, want %0d", got.avg_i, want.avg_i));
         if (got.avg_q !== want.avg_q)
            note_mismatch($sformatf("avg_q %0d, want %0d", got.avg_q, want.avg_q));
         if (got.frame_last !== want.frame_last)
            note_mismatch($sformatf("frame_last %b, want %b",
                                    got.frame_last, want.frame_last));
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [FRAME_W-1:0] csr_wdata;
   logic               req_valid;
   logic               req_stall;
   iqbd_req_type       req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   iqbd_rsp_type       rsp_data;

   boxcar_tracker book;
   int unsigned   cycle_count = 0;
   int unsigned   samples_sent = 0;
   int unsigned   length_writes = 0;
   bit            tx_gaps = 1'b1;
   bit            rx_gaps = 1'b1;

   iq_boxcar_decimator_core uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog
   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("timed out after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
   end

   // Result side: random stall before each transfer, then check it
   initial begin
      int unsigned hold;
      rsp_stall <= 1'b1;
      wait (reset === 1'b1);
      wait (reset === 1'b0);
      forever begin
         hold = rx_gaps ? $urandom_range(0, MAX_WAIT) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         book.match_average(rsp_data);
      end
   end

   function automatic iqbd_req_type iq(int i_val, int q_val);
      iqbd_req_type s;
      s.sample_i = i_val[SAMPLE_W-1:0];
      s.sample_q = q_val[SAMPLE_W-1:0];
      return s;
   endfunction

   // Sample values, leaning on the extremes
   function automatic logic signed [SAMPLE_W-1:0] pick_value(fill_kind_type kind);
      case (kind)
         FILL_HIGH: return 16'sh7FFF;
         FILL_LOW:  return 16'sh8000;
         default: begin
            case ($urandom_range(0, 7))
               0:       return 16'sh7FFF;
               1:       return 16'sh8000;
               2:       return 16'sh0000;
               3:       return 16'shFFFF;
               default: return SAMPLE_W'($urandom);
            endcase
         end
      endcase
   endfunction

   // One request transfer after a random gap
   task automatic send_sample(input iqbd_req_type s);
      int unsigned gap;
      gap = tx_gaps ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      book.take_sample(s);
      samples_sent++;
   endtask

   // Hold off the sender until every owed average has come out
   task automatic wait_for_means();
      req_valid <= 1'b0;
      do @(posedge clock); while (book.owed() != 0);
   endtask

   // Length writes only once the block has drained
   task automatic write_length(input logic [FRAME_W-1:0] len);
      wait_for_means();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      csr_we <= 1'b0;
      book.set_length(len);
      length_writes++;
   endtask

   task automatic run_phase(input logic [FRAME_W-1:0] len, input int unsigned count,
                            input fill_kind_type kind);
      iqbd_req_type s;
      write_length(len);
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      repeat (count) begin
         if ($urandom_range(0, 99) == 0) wait_for_means();
         s.sample_i = pick_value(kind);
         s.sample_q = pick_value(kind);
         send_sample(s);
      end
   endtask

   initial begin
      int unsigned        pick, count, win;
      logic [FRAME_W-1:0] len;
      fill_kind_type      kind;

      book = new();
      reset     <= 1'b1;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset length gives one-sample windows: field extremes
      send_sample(iq(32767, -32768));
      send_sample(iq(-32768, 32767));
      send_sample(iq(0, 0));
      send_sample(iq(-1, -1));
      send_sample(iq(1, -1));

      // Zero length acts as one: every sample closes a frame
      write_length('0);
      send_sample(iq(12345, -12345));
      send_sample(iq(-2, 2));
      write_length(21'd1);
      send_sample(iq(-32768, -32768));

      // Three-sample frame, then the first sample of the next
      write_length(21'd3);
      send_sample(iq(100, -100));
      send_sample(iq(-32768, 32767));
      send_sample(iq(32767, -32768));
      send_sample(iq(7, -7));

      // Two-sample windows: floor of odd negative sums
      write_length(21'd2048);
      send_sample(iq(-32768, -1));
      send_sample(iq(-32767, 0));
      send_sample(iq(32767, 32767));
      send_sample(iq(32767, 32766));

      // Oversized length clamps to the frame limit; rewrite restarts mid-frame
      write_length('1);
      send_sample(iq(-5, 5));
      send_sample(iq(32767, -32768));
      send_sample(iq(0, -1));
      write_length(MAX_FRAME_SAMPLES);
      send_sample(iq(-1, 0));
      send_sample(iq(1, 1));

      // Leftover samples past the last window, running into the next frame
      len = FRAME_W'(1024 + $urandom_range(1, 16));
      run_phase(len, len + $urandom_range(1, 8), FILL_RANDOM);
      // Oversized length: one full 1024-sample window at the most negative sum
      run_phase('1, 1024 + $urandom_range(0, 40), FILL_LOW);

      // Short frames and mid-size windows at random
      while (samples_sent < 2300) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            len = FRAME_W'($urandom_range(1, 64));
            count = len * $urandom_range(1, 3) + $urandom_range(0, len);
         end else if (pick == 6) begin
            len = '0;
            count = $urandom_range(1, 6);
         end else begin
            len = FRAME_W'($urandom_range(2048, 24575));
            win = len / 1024;
            count = win * $urandom_range(1, 5) + $urandom_range(0, win - 1);
         end
         case ($urandom_range(0, 7))
            0:       kind = FILL_HIGH;
            1:       kind = FILL_LOW;
            default: kind = FILL_RANDOM;
         endcase
         run_phase(len, count, kind);
      end

      wait_for_means();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d samples across %0d frame length settings",
               samples_sent, length_writes);
      $display("checked %0d averages, %0d mismatches", book.checked, book.mismatches);
      if (book.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
